>>> sv/dtfp_pkg.sv
// Shared types, character codes and helper functions for the decimal text parser.
// No dependencies; used by dtfp_scanner, decimal_text_to_fixed_parser, dtfp_checker and the testbench.
`timescale 1ns / 1ps

package dtfp_pkg;

  // ASCII codes that the scanner tests against.
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic {
    PH_SKIP,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_SYNTAX = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  // Narrow scanner state that the sequencer samples on the terminator.
  typedef struct packed {
    logic       negative;
    logic       syntax_bad;
    logic       fraction_nonzero;
    logic [1:0] integer_part;
  } scan_flags_t;

  // Bits needed to hold 10**k, evaluated at elaboration only.
  function automatic int dig_width(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd10;
    end
    return $clog2(p);
  endfunction

endpackage

>>> sv/dtfp_scanner.sv
// Character scanner: whitespace skip, sign, integer and fraction digit accumulators.
// Depends on dtfp_pkg for character codes, the phase enum and the flag struct.
`timescale 1ns / 1ps

module dtfp_scanner #(
  parameter int KEPT_FRAC_DIGITS = 9,
  parameter int DIG_W            = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 clear_i,
  input  logic [7:0]           char_i,
  output dtfp_pkg::scan_flags_t flags_o,
  output logic [DIG_W-1:0]     digits_o,
  output logic [DIG_W-1:0]     den_o
);

  localparam int CNT_W = $clog2(KEPT_FRAC_DIGITS + 1);

  dtfp_pkg::phase_e phase_q, phase_d;
  logic             neg_q, neg_d;
  logic             point_q, point_d;
  logic             bad_q, bad_d;
  logic [1:0]       int_q, int_d;
  logic [DIG_W-1:0] digits_q, digits_d;
  logic [DIG_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             nz_q, nz_d;

  logic             body;
  logic [7:0]       diff;
  logic [3:0]       digit;
  logic [5:0]       int_v;

  assign diff  = char_i - dtfp_pkg::CH_ZERO;
  assign digit = diff[3:0];
  assign int_v = 6'(int_q) * 6'd10 + 6'(digit);

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    point_d  = point_q;
    bad_d    = bad_q;
    int_d    = int_q;
    digits_d = digits_q;
    den_d    = den_q;
    cnt_d    = cnt_q;
    nz_d     = nz_q;
    body     = 1'b0;
    if (clear_i) begin
      phase_d  = dtfp_pkg::PH_SKIP;
      neg_d    = 1'b0;
      point_d  = 1'b0;
      bad_d    = 1'b0;
      int_d    = 2'd0;
      digits_d = '0;
      den_d    = DIG_W'(1);
      cnt_d    = '0;
      nz_d     = 1'b0;
    end else if (take_i) begin
      if (phase_q == dtfp_pkg::PH_SKIP) begin
        if (!(char_i inside {dtfp_pkg::CH_SPACE, [dtfp_pkg::CH_TAB:dtfp_pkg::CH_CR]})) begin
          phase_d = dtfp_pkg::PH_BODY;
          if (char_i == dtfp_pkg::CH_PLUS || char_i == dtfp_pkg::CH_MINUS) begin
            neg_d = (char_i == dtfp_pkg::CH_MINUS);
          end else begin
            body = 1'b1;
          end
        end
      end else begin
        body = 1'b1;
      end
    end

    if (body) begin
      if (char_i == dtfp_pkg::CH_POINT) begin
        if (point_q) begin
          bad_d = 1'b1;
        end
        point_d = 1'b1;
      end else if (char_i inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]}) begin
        if (!point_q) begin
          int_d = (int_v > 6'd3) ? 2'd3 : int_v[1:0];
        end else if (cnt_q < CNT_W'(KEPT_FRAC_DIGITS)) begin
          // Times ten as two shifts and an add; the value stays below 10**kept.
          digits_d = DIG_W'((digits_q << 3) + (digits_q << 1) + DIG_W'(digit));
          den_d    = DIG_W'((den_q << 3) + (den_q << 1));
          cnt_d    = cnt_q + CNT_W'(1);
        end else if (digit != 4'd0) begin
          nz_d = 1'b1;
        end
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dtfp_pkg::PH_SKIP;
      neg_q    <= 1'b0;
      point_q  <= 1'b0;
      bad_q    <= 1'b0;
      int_q    <= 2'd0;
      digits_q <= '0;
      den_q    <= DIG_W'(1);
      cnt_q    <= '0;
      nz_q     <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      point_q  <= point_d;
      bad_q    <= bad_d;
      int_q    <= int_d;
      digits_q <= digits_d;
      den_q    <= den_d;
      cnt_q    <= cnt_d;
      nz_q     <= nz_d;
    end
  end

  assign flags_o.negative         = neg_q;
  assign flags_o.syntax_bad       = bad_q;
  assign flags_o.fraction_nonzero = nz_q;
  assign flags_o.integer_part     = int_q;
  assign digits_o                 = digits_q;
  assign den_o                    = den_q;

endmodule

>>> sv/dtfp_divider.sv
// Restoring divider: one shared compare-and-subtract step per cycle, one quotient bit each.
// Produces floor(dividend * 2**FRAC_BITS / divisor) for dividend below divisor. No package use.
`timescale 1ns / 1ps

module dtfp_divider #(
  parameter int FRAC_BITS = 28,
  parameter int DIG_W     = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIG_W-1:0]     dividend_i,
  input  logic [DIG_W-1:0]     divisor_i,
  output logic [FRAC_BITS-1:0] quotient_o,
  output logic                 done_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [DIG_W-1:0]     rem_q, rem_d;
  logic [DIG_W-1:0]     den_q;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIG_W:0]       rem2;
  logic                 fits;

  assign rem2 = {rem_q, 1'b0};
  assign fits = (rem2 >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i;
      quo_d = '0;
      cnt_d = CNT_W'(FRAC_BITS);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? DIG_W'(rem2 - {1'b0, den_q}) : DIG_W'(rem2);
      quo_d  = {quo_q[FRAC_BITS-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> sv/decimal_text_to_fixed_parser.sv
// Top level of the decimal text to signed fixed-point parser and its sequencer.
// Depends on dtfp_pkg, dtfp_scanner and dtfp_divider.
//
// Usage: send the ASCII text of a number on the slave stream, one character per
// transaction in tdata, then a terminator transaction with tlast high (its tdata is
// ignored). tuser carries the component tag, which is echoed with the result.
// Each terminator yields one result on the master stream: the value in tdata
// (signed, FRAC_BITS fraction bits, zero unless the status is ok) and in tuser the
// status (ok, syntax error, magnitude above two) and the echoed tag.
// Characters are taken while the sequencer is idle. After a valid terminator tready
// stays low while the divider forms the quotient, while its done flag is registered
// and until the output register is loaded, and the result is valid once that
// register is loaded. After an error terminator tready is low only until the output
// register is loaded, which waits while an earlier result is still not taken.
// The result waits in an output register; while it is not taken the block keeps
// reading characters, and a further terminator is taken but then holds tready low
// until that register frees.
// Reset returns the scanner to whitespace skipping and drops any pending result.
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser #(
  parameter int FRAC_BITS        = 28,
  parameter int KEPT_FRAC_DIGITS = 9
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [7:0]                              s_axis_tdata_i,  // [7:0] character
  input  logic                                    s_axis_tlast_i,  // end_of_string
  input  logic                                    s_axis_tuser_i,  // [0] component
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [((FRAC_BITS + 3 + 7) / 8) * 8-1:0] m_axis_tdata_o, // value, zero pad
  output logic [2:0]                              m_axis_tuser_o   // [1:0] status, [2] comp
);

  localparam int VAL_W   = FRAC_BITS + 3;
  localparam int TDATA_W = ((FRAC_BITS + 3 + 7) / 8) * 8;
  localparam int DIG_W   = dtfp_pkg::dig_width(KEPT_FRAC_DIGITS);

  dtfp_pkg::state_e      state_q, state_d;
  dtfp_pkg::scan_flags_t flags;
  logic [DIG_W-1:0]      digits;
  logic [DIG_W-1:0]      den;
  logic [FRAC_BITS-1:0]  quotient;
  logic                  div_done;
  logic                  div_start;
  logic                  in_acc;
  logic                  term_acc;
  logic                  load_out;
  logic                  range_bad;
  dtfp_pkg::status_e     stat_now;

  dtfp_pkg::status_e     stat_q;
  logic                  neg_q;
  logic [1:0]            int_q;
  logic                  comp_q;

  logic                  m_valid_q, m_valid_d;
  logic [VAL_W-1:0]      m_value_q;
  dtfp_pkg::status_e     m_stat_q;
  logic                  m_comp_q;
  logic [VAL_W-1:0]      mag;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign term_acc = in_acc && s_axis_tlast_i;

  dtfp_scanner #(
    .KEPT_FRAC_DIGITS(KEPT_FRAC_DIGITS),
    .DIG_W           (DIG_W)
  ) u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_acc && !s_axis_tlast_i),
    .clear_i (term_acc),
    .char_i  (s_axis_tdata_i),
    .flags_o (flags),
    .digits_o(digits),
    .den_o   (den)
  );

  dtfp_divider #(
    .FRAC_BITS(FRAC_BITS),
    .DIG_W    (DIG_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(digits),
    .divisor_i (den),
    .quotient_o(quotient),
    .done_o    (div_done)
  );

  // Exact range test: an integer part of two passes only with an all-zero fraction,
  // dropped digits included.
  assign range_bad = (flags.integer_part == 2'd3) ||
                     (flags.integer_part == 2'd2 &&
                      (digits != '0 || flags.fraction_nonzero));

  always_comb begin
    if (flags.syntax_bad) begin
      stat_now = dtfp_pkg::STAT_SYNTAX;
    end else if (range_bad) begin
      stat_now = dtfp_pkg::STAT_RANGE;
    end else begin
      stat_now = dtfp_pkg::STAT_OK;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtfp_pkg::ST_IDLE: begin
        if (term_acc) begin
          state_d = (stat_now == dtfp_pkg::STAT_OK) ? dtfp_pkg::ST_DIV : dtfp_pkg::ST_OUT;
        end
      end
      dtfp_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = dtfp_pkg::ST_OUT;
        end
      end
      dtfp_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = dtfp_pkg::ST_IDLE;
        end
      end
      default: state_d = dtfp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      dtfp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        div_start       = term_acc && (stat_now == dtfp_pkg::STAT_OK);
      end
      dtfp_pkg::ST_DIV: begin
      end
      dtfp_pkg::ST_OUT: begin
        load_out = !m_valid_q || m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  assign mag = (stat_q == dtfp_pkg::STAT_OK) ? {1'b0, int_q, quotient} : '0;

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtfp_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_acc) begin
      stat_q <= stat_now;
      neg_q  <= flags.negative;
      int_q  <= flags.integer_part;
      comp_q <= s_axis_tuser_i;
    end
    if (load_out) begin
      m_value_q <= neg_q ? (VAL_W'(0) - mag) : mag;
      m_stat_q  <= stat_q;
      m_comp_q  <= comp_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(m_value_q);
  assign m_axis_tuser_o  = {m_comp_q, m_stat_q};

  // An error result never carries a nonzero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] != dtfp_pkg::STAT_OK |->
      m_axis_tdata_o == '0)
    else $error("error result with nonzero value");

  // Status code three is never produced.
  a_no_code3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o[1:0] != 2'b11)
    else $error("invalid status code");

  // A terminator always takes the block out of the idle state.
  a_term_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("terminator did not stall input");

  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == dtfp_pkg::ST_DIV)
    else $error("divider done outside divide state");

endmodule

>>> sim/dtfp_checker.sv
// Scoreboard for the decimal text parser: follows both streams, predicts each number.
// Depends on dtfp_pkg for character codes, scan phases and status codes.
`timescale 1ns / 1ps

module dtfp_checker #(
  parameter int FRAC_BITS        = 28,
  parameter int KEPT_FRAC_DIGITS = 9,
  parameter int TDATA_W          = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [7:0]         s_axis_tdata_i,  // [7:0] character
  input  logic               s_axis_tlast_i,  // end_of_string
  input  logic               s_axis_tuser_i,  // [0] component
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [TDATA_W-1:0] m_axis_tdata_i,  // value, zero pad
  input  logic [2:0]         m_axis_tuser_i,  // [1:0] status, [2] component
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 ok_seen_o,
  output int                 syntax_seen_o,
  output int                 range_seen_o
);

  typedef struct packed {
    logic [FRAC_BITS+2:0] value;
    dtfp_pkg::status_e    status;
    logic                 comp;
  } number_t;

  dtfp_pkg::phase_e  scan_phase;
  logic              is_negative;
  logic              point_seen;
  logic              syntax_bad;
  int unsigned       int_part;
  longint unsigned   frac_digits;
  int unsigned       frac_count;
  logic              frac_tail_nonzero;

  number_t expected_numbers_q[$];
  int      mismatches = 0;
  int      n_ok       = 0;
  int      n_syntax   = 0;
  int      n_range    = 0;
  int      n_results  = 0;

  assign fail_count_o  = mismatches;
  assign ok_seen_o     = n_ok;
  assign syntax_seen_o = n_syntax;
  assign range_seen_o  = n_range;

  task automatic report(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic clear_scan();
    scan_phase        = dtfp_pkg::PH_SKIP;
    is_negative       = 1'b0;
    point_seen        = 1'b0;
    syntax_bad        = 1'b0;
    int_part          = 0;
    frac_digits       = 0;
    frac_count        = 0;
    frac_tail_nonzero = 1'b0;
  endtask

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == dtfp_pkg::CH_SPACE || (ch >= dtfp_pkg::CH_TAB && ch <= dtfp_pkg::CH_CR);
  endfunction

  task automatic absorb_character(input logic [7:0] ch);
    int unsigned d;
    int unsigned grown;
    d = int'(ch) - int'(dtfp_pkg::CH_ZERO);
    if (scan_phase == dtfp_pkg::PH_SKIP &&
        (ch == dtfp_pkg::CH_PLUS || ch == dtfp_pkg::CH_MINUS)) begin
      scan_phase  = dtfp_pkg::PH_BODY;
      is_negative = (ch == dtfp_pkg::CH_MINUS);
    end else if (!(scan_phase == dtfp_pkg::PH_SKIP && is_blank(ch))) begin
      scan_phase = dtfp_pkg::PH_BODY;
      if (ch == dtfp_pkg::CH_POINT) begin
        if (point_seen) syntax_bad = 1'b1;
        point_seen = 1'b1;
      end else if (ch >= dtfp_pkg::CH_ZERO && ch <= dtfp_pkg::CH_NINE) begin
        if (!point_seen) begin
          // The integer part only needs to tell 0, 1, 2 and "too big" apart.
          grown    = int_part * 10 + d;
          int_part = (grown > 3) ? 3 : grown;
        end else if (frac_count < KEPT_FRAC_DIGITS) begin
          frac_digits = frac_digits * 10 + d;
          frac_count++;
        end else if (d != 0) begin
          frac_tail_nonzero = 1'b1;
        end
      end else begin
        syntax_bad = 1'b1;
      end
    end
  endtask

  function automatic number_t convert_number(input logic comp);
    number_t         r;
    longint unsigned scale;
    longint unsigned mag;
    r.comp  = comp;
    r.value = '0;
    if (syntax_bad) begin
      r.status = dtfp_pkg::STAT_SYNTAX;
    end else if (int_part >= 3 ||
                 (int_part == 2 && (frac_digits != 0 || frac_tail_nonzero))) begin
      r.status = dtfp_pkg::STAT_RANGE;
    end else begin
      r.status = dtfp_pkg::STAT_OK;
      scale = 1;
      for (int i = 0; i < frac_count; i++) scale = scale * 10;
      // The fraction is truncated toward zero, as the hardware divider does.
      mag = (longint'(int_part) << FRAC_BITS) | ((frac_digits << FRAC_BITS) / scale);
      if (is_negative) mag = 64'd0 - mag;
      r.value = mag[FRAC_BITS+2:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    number_t            want;
    logic [TDATA_W-1:0] want_bits;
    if (!rst_ni) begin
      clear_scan();
      expected_numbers_q.delete();
      pending_o <= 0;
    end else begin
      // A result can never belong to a terminator taken at the same edge,
      // so the master side is checked before the slave side is absorbed.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        n_results++;
        if (expected_numbers_q.size() == 0) begin
          report($sformatf("result %0d arrived with no number outstanding", n_results));
        end else begin
          want      = expected_numbers_q.pop_front();
          want_bits = '0;
          want_bits[FRAC_BITS+2:0] = want.value;
          case (want.status)
            dtfp_pkg::STAT_OK:     n_ok++;
            dtfp_pkg::STAT_SYNTAX: n_syntax++;
            default:               n_range++;
          endcase
          if (m_axis_tdata_i !== want_bits || m_axis_tuser_i[1:0] !== want.status ||
              m_axis_tuser_i[2] !== want.comp) begin
            report($sformatf("result %0d: value %h/%h status %0d/%0d tag %0d/%0d (got/want)",
                             n_results, m_axis_tdata_i, want_bits, m_axis_tuser_i[1:0],
                             want.status, m_axis_tuser_i[2], want.comp));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tlast_i) begin
          expected_numbers_q.push_back(convert_number(s_axis_tuser_i));
          clear_scan();
        end else begin
          absorb_character(s_axis_tdata_i);
        end
      end
      pending_o <= expected_numbers_q.size();
    end
  end

endmodule

>>> sim/tb_decimal_text_to_fixed_parser.sv
// Testbench top for decimal_text_to_fixed_parser: drives number text on the slave stream and stalls the result stream.
// Depends on dtfp_pkg, the parser RTL and dtfp_checker, which predicts and compares.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_parser;

  localparam int FRAC_BITS        = 28;
  localparam int KEPT_FRAC_DIGITS = 9;
  localparam int TDATA_W          = ((FRAC_BITS + 3 + 7) / 8) * 8;
  localparam int NUM_ITEMS        = 1650;
  localparam int MAX_GAP          = 17;
  localparam int SETTLE_CYCLES    = FRAC_BITS + 12;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_HIGH  = 8'hFF;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid   = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata    = '0;
  logic               s_axis_tlast    = 1'b0;
  logic               s_axis_tuser    = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready   = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [2:0]         m_axis_tuser;

  int   fail_count;
  int   pending;
  int   ok_seen;
  int   syntax_seen;
  int   range_seen;
  int   items_sent   = 0;
  int   strings_sent = 0;
  logic tx_rush      = 1'b0;
  logic rx_rush      = 1'b0;

  logic [7:0] text_buf[32];
  int         text_len;

  decimal_text_to_fixed_parser #(
    .FRAC_BITS       (FRAC_BITS),
    .KEPT_FRAC_DIGITS(KEPT_FRAC_DIGITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  dtfp_checker #(
    .FRAC_BITS       (FRAC_BITS),
    .KEPT_FRAC_DIGITS(KEPT_FRAC_DIGITS),
    .TDATA_W         (TDATA_W)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .ok_seen_o      (ok_seen),
    .syntax_seen_o  (syntax_seen),
    .range_seen_o   (range_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d numbers outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: a fresh stall length for every result transaction.
  initial begin : result_sink
    int gap;
    forever begin
      gap = rx_rush ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eos, input logic comp);
    int gap;
    gap = tx_rush ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eos;
    s_axis_tuser  <= comp;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Sends the buffered text, then a terminator whose data byte is random noise.
  task automatic send_text();
    for (int i = 0; i < text_len; i++) send_item(text_buf[i], 1'b0, 1'($urandom_range(0, 1)));
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    strings_sent++;
  endtask

  task automatic run_text(input string s);
    text_len = s.len();
    for (int i = 0; i < text_len; i++) text_buf[i] = s[i];
    send_text();
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic push_char(input logic [7:0] ch);
    text_buf[text_len] = ch;
    text_len++;
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? dtfp_pkg::CH_SPACE : dtfp_pkg::CH_TAB + 8'(k);
  endfunction

  // Mostly well-formed numbers around the range limit, some corrupted, a few pure noise.
  task automatic build_random_text();
    int         kind;
    int         n_int;
    int         pos;
    logic [7:0] junk;
    text_len = 0;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) repeat ($urandom_range(0, 3)) push_char(blank_char());
      case ($urandom_range(0, 2))
        1:       push_char(dtfp_pkg::CH_PLUS);
        2:       push_char(dtfp_pkg::CH_MINUS);
        default: ;
      endcase
      if (kind <= 3) begin
        // Two followed by zeros, possibly then a nonzero digit, at times past the kept ones.
        push_char(dtfp_pkg::CH_ZERO + 8'd2);
        push_char(dtfp_pkg::CH_POINT);
        repeat ($urandom_range(0, 11)) push_char(dtfp_pkg::CH_ZERO);
        if ($urandom_range(0, 1)) push_char(dtfp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      end else begin
        n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
        for (int i = 0; i < n_int; i++)
          push_char(dtfp_pkg::CH_ZERO +
                    8'((i == 0) ? $urandom_range(0, 2) : $urandom_range(0, 9)));
        if ($urandom_range(0, 3) != 0) begin
          push_char(dtfp_pkg::CH_POINT);
          repeat ($urandom_range(0, 12))
            push_char(dtfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      if (kind >= 16) begin
        case ($urandom_range(0, 4))
          0:       junk = 8'($urandom_range(0, 255));
          1:       junk = dtfp_pkg::CH_POINT;
          2:       junk = dtfp_pkg::CH_PLUS;
          3:       junk = dtfp_pkg::CH_MINUS;
          default: junk = blank_char();
        endcase
        pos = $urandom_range(0, text_len);
        for (int i = text_len; i > pos; i--) text_buf[i] = text_buf[i-1];
        text_buf[pos] = junk;
        text_len++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_text("");
    run_text("+");
    run_text(".");
    run_text("..");
    run_text("--");
    run_text("1 ");
    run_text("9+");
    run_text("-2");
    text_buf[0] = CH_VT;
    text_buf[1] = dtfp_pkg::CH_MINUS;
    text_buf[2] = dtfp_pkg::CH_ZERO;
    text_len    = 3;
    send_text();
    text_buf[0] = CH_HIGH;
    text_len    = 1;
    send_text();
    drain_results();

    while (items_sent < NUM_ITEMS) begin
      tx_rush <= ($urandom_range(0, 7) == 0);
      rx_rush <= ($urandom_range(0, 7) == 0);
      build_random_text();
      send_text();
      if (strings_sent % 60 == 0) drain_results();
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions forming %0d number strings, with random stalls.",
             items_sent, strings_sent);
    $display("Numbers checked: %0d ok, %0d syntax errors, %0d out of range.",
             ok_seen, syntax_seen, range_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dtfp_pkg.sv
sv/dtfp_scanner.sv
sv/dtfp_divider.sv
sv/decimal_text_to_fixed_parser.sv
sim/dtfp_checker.sv
sim/tb_decimal_text_to_fixed_parser.sv
